@@ hw/rtl/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int CMD_W      = 1;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int TSIZE_W    = 11;
    localparam int POSITION_W = 10;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

endpackage

@@ hw/rtl/stbs_ram.sv @@
// ----------------------------------------------------------------------------
// stbs_ram
// Simple dual-port table memory: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int DEPTH      = stbs_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEFAULT,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a table of signed entries held in on-chip memory.
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores one entry and returns nothing. A search
// request (cmd 1) probes the first table_size entries, clipped to the
// memory depth, one probe per clock through the table memory's single
// read port, with at most floor(log2(n)) + 1 probes, i.e. 11 for a full
// 1024-entry table; an empty table is answered without a probe. The result
// sits in an output register until taken; a new request is taken once the
// search has posted it. Entries are not cleared at reset: every entry a
// search can reach must be written first. table_size may only be written
// while no request is open.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int DEPTH      = stbs_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stbs_pkg::TSIZE_W-1:0]          cfg_table_size,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [stbs_pkg::CMD_W-1:0]            s_cmd,
    input  logic [stbs_pkg::INDEX_W-1:0]          s_entry_index,
    input  logic signed [stbs_pkg::VALUE_W-1:0]   s_value,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic [stbs_pkg::POSITION_W-1:0]       m_position
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = ($clog2(DEPTH + 1) > stbs_pkg::TSIZE_W) ?
                           $clog2(DEPTH + 1) : stbs_pkg::TSIZE_W;
    localparam int CMP_W = (DATA_WIDTH > stbs_pkg::VALUE_W) ? DATA_WIDTH : stbs_pkg::VALUE_W;
    localparam int XW    = (IW > stbs_pkg::INDEX_W) ? IW : stbs_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [stbs_pkg::TSIZE_W-1:0]        tsize_reg;
    logic [IW-1:0]                       lo_reg, lo_next;
    logic [IW-1:0]                       hi_reg, hi_next;
    logic [IW-1:0]                       mid_reg, mid_next;
    logic signed [CMP_W-1:0]             key_reg, key_next;
    logic                                res_found_reg, res_found_next;
    logic [IW-1:0]                       res_pos_reg, res_pos_next;
    logic                                m_valid_reg, m_valid_next;
    logic                                m_found_reg, m_found_next;
    logic [stbs_pkg::POSITION_W-1:0]     m_position_reg, m_position_next;

    logic                                s_accept;
    logic                                slot_free;
    logic [NW-1:0]                       tsize_x;
    logic [NW-1:0]                       n_clip;
    logic [IW-1:0]                       hi_init;
    logic [IW:0]                         sum_init;
    logic [IW:0]                         sum_down;
    logic [IW:0]                         sum_up;
    logic [IW-1:0]                       mid_dec;
    logic [IW-1:0]                       mid_inc;

    logic                                wr_en;
    logic [XW-1:0]                       idx_x;
    logic [CMP_W-1:0]                    val_zx;
    logic [DATA_WIDTH-1:0]               rd_data;
    logic signed [CMP_W-1:0]             entry_ext;
    logic [XW-1:0]                       pos_x;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // Clip table_size to the memory depth.
    assign tsize_x  = NW'(tsize_reg);
    assign n_clip   = (tsize_x > NW'(DEPTH)) ? NW'(DEPTH) : tsize_x;
    assign hi_init  = IW'(n_clip - NW'(1));
    assign sum_init = {1'b0, hi_init};

    // Both candidate next midpoints are formed ahead of the compare.
    assign mid_dec  = mid_reg - IW'(1);
    assign mid_inc  = mid_reg + IW'(1);
    assign sum_down = {1'b0, lo_reg} + {1'b0, mid_dec};
    assign sum_up   = {1'b0, mid_inc} + {1'b0, hi_reg};

    assign idx_x  = XW'(s_entry_index);
    assign val_zx = CMP_W'($unsigned(s_value));
    assign wr_en  = s_accept && (s_cmd == stbs_pkg::CMD_WRITE) &&
                    (32'(s_entry_index) < 32'(DEPTH));

    assign entry_ext = CMP_W'(signed'(rd_data));

    stbs_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_x[IW-1:0]),
        .wr_data (val_zx[DATA_WIDTH-1:0]),
        .rd_addr (mid_next),
        .rd_data (rd_data)
    );

    assign pos_x = XW'(res_pos_reg);

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_position_next = m_position_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_cmd == stbs_pkg::CMD_SEARCH)) begin
                    key_next       = CMP_W'(s_value);
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    lo_next        = '0;
                    hi_next        = hi_init;
                    mid_next       = sum_init[IW:1];
                    if (n_clip == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // rd_data holds the entry at mid_reg
                priority if (key_reg == entry_ext) begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_reg;
                    state_next     = S_DONE;
                end else if (key_reg < entry_ext) begin
                    if (mid_reg == lo_reg) begin
                        state_next = S_DONE;
                    end else begin
                        hi_next  = mid_dec;
                        mid_next = sum_down[IW:1];
                    end
                end else begin
                    if (mid_reg == hi_reg) begin
                        state_next = S_DONE;
                    end else begin
                        lo_next  = mid_inc;
                        mid_next = sum_up[IW:1];
                    end
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = res_found_reg;
                    m_position_next = pos_x[stbs_pkg::POSITION_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tsize_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                tsize_reg <= cfg_table_size;
            end
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        m_found_reg    <= m_found_next;
        m_position_reg <= m_position_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

    // Bounds stay ordered and inside the clipped table while probing.
    a_probe_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (lo_reg <= mid_reg) && (mid_reg <= hi_reg))
        else $error("probe midpoint outside search bounds");

    a_probe_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (NW'(hi_reg) < n_clip))
        else $error("probe bound beyond table size");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result posted outside completion");

    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_position_reg == '0))
        else $error("not-found result with nonzero position");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_table_binary_search. Loads the table, changes
// table_size between phases and fires keyed searches under random stalls.
// A model of the table mirrors every accepted write and predicts the
// found flag and position of every search.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic signed [stbs_pkg::VALUE_W-1:0] value_t;
    typedef logic [stbs_pkg::INDEX_W-1:0]        index_t;
    typedef logic [stbs_pkg::CMD_W-1:0]          cmd_t;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam int ITEM_TARGET = 950;
    localparam int SEARCH_LATENCY = 16;

    typedef struct packed {
        logic                            found;
        logic [stbs_pkg::POSITION_W-1:0] position;
    } answer_t;

    typedef enum {FILL_ASCENDING, FILL_REPEATS, FILL_SCRAMBLED} fill_mode_t;

    // Mirror of the table plus the queue of answers still owed by the block.
    class search_scoreboard;
        value_t                    entries [stbs_pkg::DEPTH_DEFAULT];
        bit                        fresh [stbs_pkg::DEPTH_DEFAULT];
        int                        active_len;
        answer_t                   awaited [$];
        int                        errors;

        function new();
            foreach (entries[i]) begin
                entries[i] = '0;
                fresh[i] = 1'b0;
            end
            active_len = 0;
            errors = 0;
        endfunction

        // Clamps to the table depth; entries must be written again before use.
        function void set_table_size(int unsigned size);
            active_len = (size > stbs_pkg::DEPTH_DEFAULT) ? stbs_pkg::DEPTH_DEFAULT
                                                          : int'(size);
            foreach (fresh[i])
                fresh[i] = 1'b0;
        endfunction

        // stale returns the first probed entry not written since the last
        // size change, or -1 when the whole probe path is known.
        function void probe_table(input value_t key,
                                  output answer_t ans, output int stale);
            int lo, hi, mid;
            ans = '0;
            stale = -1;
            lo = 0;
            hi = active_len - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (!fresh[mid]) begin
                    stale = mid;
                    break;
                end
                if (key == entries[mid]) begin
                    ans.found = 1'b1;
                    ans.position = mid[stbs_pkg::POSITION_W-1:0];
                    break;
                end
                if (key < entries[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        endfunction

        function void note_request(cmd_t cmd, index_t idx, value_t value);
            answer_t ans;
            int      stale;
            if (cmd == stbs_pkg::CMD_WRITE) begin
                entries[idx] = value;
                fresh[idx] = 1'b1;
            end else begin
                probe_table(value, ans, stale);
                awaited.push_back(ans);
            end
        endfunction

        function void check_result(logic found, logic [stbs_pkg::POSITION_W-1:0] position);
            answer_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result with no search open: expected none, %s%0b position=%0d",
                         $time, "actual found=", found, position);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (found !== want.found) begin
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, want.found, found);
                errors++;
            end
            if (position !== want.position) begin
                $display("%0t: position mismatch: expected %0d, actual %0d",
                         $time, want.position, position);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [stbs_pkg::TSIZE_W-1:0]        cfg_table_size;
    logic                                s_valid;
    logic                                s_ready;
    cmd_t                                s_cmd;
    index_t                              s_entry_index;
    value_t                              s_value;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_found;
    logic [stbs_pkg::POSITION_W-1:0]     m_position;

    search_scoreboard           sb;
    value_t                     plan_vals [stbs_pkg::DEPTH_DEFAULT];
    int                         table_len;
    int                         items_sent;
    bit                         steady;

    sorted_table_binary_search dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_table_size (cfg_table_size),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_entry_index  (s_entry_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_position     (m_position)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Lowers valid only when a gap follows, so valid never drops and rises
    // within one time step.
    task automatic send_request(cmd_t cmd, index_t idx, value_t value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_entry_index <= idx;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, idx, value);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0)
            @(posedge aclk);
    endtask

    // A trailing write may still be in flight after the last result.
    task automatic load_size(int unsigned size);
        settle();
        repeat (SEARCH_LATENCY) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_table_size <= size[stbs_pkg::TSIZE_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_table_size(size);
        table_len = sb.active_len;
    endtask

    // Fills any probe-path entry not yet written this phase before searching.
    task automatic search_key(value_t key);
        answer_t ans;
        int      stale;
        sb.probe_table(key, ans, stale);
        while (stale >= 0) begin
            send_request(stbs_pkg::CMD_WRITE, stale[stbs_pkg::INDEX_W-1:0], plan_vals[stale]);
            sb.probe_table(key, ans, stale);
        end
        send_request(stbs_pkg::CMD_SEARCH, index_t'($urandom), key);
    endtask

    function automatic void plan_table(fill_mode_t mode);
        longint unsigned span;
        longint          step, room, base, v;
        int              k;
        if (table_len == 0)
            return;
        if (mode == FILL_SCRAMBLED) begin
            k = $urandom_range(0, 1);
            for (int i = 0; i < table_len; i++)
                plan_vals[i] = k ? value_t'($urandom) : value_t'($urandom_range(0, 8) - 4);
            return;
        end
        k = (mode == FILL_REPEATS) ? $urandom_range(2, 4) : 1;
        span = 64'h1_0000_0000 / longint'(table_len);
        if ($urandom_range(0, 1) && span > 16)
            span = 16;
        step = 1 + longint'({$urandom, $urandom} % span);
        room = 64'h1_0000_0000 - longint'(table_len) * step;
        base = -64'sd2147483648 + longint'({$urandom, $urandom} % (room + 1));
        for (int i = 0; i < table_len; i++) begin
            v = base + longint'(i / k) * step;
            if (mode == FILL_ASCENDING)
                v += longint'($urandom % step);
            plan_vals[i] = v[stbs_pkg::VALUE_W-1:0];
        end
        if ($urandom_range(0, 3) == 0) begin
            plan_vals[0] = VAL_MIN;
            plan_vals[table_len-1] = VAL_MAX;
        end
    endfunction

    function automatic value_t pick_key();
        int r, idx;
        r = $urandom_range(0, 99);
        idx = (table_len > 0) ? $urandom_range(0, table_len - 1) : 0;
        if (table_len > 0 && r < 50)
            return plan_vals[idx];
        if (table_len > 0 && r < 70)
            return r[0] ? plan_vals[idx] + 1 : plan_vals[idx] - 1;
        if (r < 80) begin
            case (r % 4)
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return value_t'($urandom);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 0;
        if (r < 16) return stbs_pkg::DEPTH_DEFAULT;
        if (r < 20) return stbs_pkg::DEPTH_DEFAULT - 1;
        if (r < 23)
            return $urandom_range(stbs_pkg::DEPTH_DEFAULT + 1, (1 << stbs_pkg::TSIZE_W) - 1);
        if (r < 45) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, 64);
        return $urandom_range(65, 400);
    endfunction

    task automatic run_phase(int unsigned size);
        int         order [stbs_pkg::DEPTH_DEFAULT];
        int         j, tmp, r, idx, searches;
        fill_mode_t mode;
        r = $urandom_range(0, 99);
        mode = (r < 60) ? FILL_ASCENDING : (r < 75) ? FILL_REPEATS : FILL_SCRAMBLED;
        load_size(size);
        plan_table(mode);
        steady = ($urandom_range(0, 3) == 0);
        // Small tables are loaded up front in shuffled order; large ones
        // are filled along the probe paths as searches need them.
        if (table_len <= 64) begin
            for (int i = 0; i < table_len; i++)
                order[i] = i;
            for (int i = table_len - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < table_len; i++)
                send_request(stbs_pkg::CMD_WRITE, order[i][stbs_pkg::INDEX_W-1:0],
                             plan_vals[order[i]]);
        end
        searches = (table_len > 64) ? $urandom_range(8, 16) : $urandom_range(10, 40);
        repeat (searches) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                idx = $urandom_range(0, stbs_pkg::DEPTH_DEFAULT - 1);
                send_request(stbs_pkg::CMD_WRITE, idx[stbs_pkg::INDEX_W-1:0],
                             (idx < table_len) ? plan_vals[idx] : value_t'($urandom));
            end else if (r < 11 && table_len > 0) begin
                // breaks the ordering on purpose
                idx = $urandom_range(0, table_len - 1);
                send_request(stbs_pkg::CMD_WRITE, idx[stbs_pkg::INDEX_W-1:0],
                             value_t'($urandom));
            end else if (r < 14) begin
                settle();
            end
            search_key(pick_key());
        end
    endtask

    initial begin : result_sink
        int  r, len;
        bit  on;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                on = 1'b1;
                len = $urandom_range(20, 200);
            end else if (r < 55) begin
                on = 1'b1;
                len = $urandom_range(1, 4);
            end else begin
                on = 1'b0;
                len = (r < 85) ? $urandom_range(1, 2)
                    : (r < 96) ? $urandom_range(3, 8) : $urandom_range(20, 40);
            end
            repeat (len) begin
                m_ready <= on;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_found, m_position);
    end

    initial begin : watchdog
        #10_000_000;
        $display("sorted_table_binary_search test failed");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_table_size = '0;
        s_valid = 1'b0;
        s_cmd = stbs_pkg::CMD_WRITE;
        s_entry_index = '0;
        s_value = '0;
        table_len = 0;
        items_sent = 0;
        steady = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table straight out of reset
        send_request(stbs_pkg::CMD_SEARCH, '1, '0);
        send_request(stbs_pkg::CMD_SEARCH, '0, -1);
        send_request(stbs_pkg::CMD_WRITE, '1, VAL_MAX);

        load_size(4);
        send_request(stbs_pkg::CMD_WRITE, 10'd2, '0);
        send_request(stbs_pkg::CMD_WRITE, 10'd0, VAL_MIN);
        send_request(stbs_pkg::CMD_WRITE, 10'd3, VAL_MAX);
        send_request(stbs_pkg::CMD_WRITE, 10'd1, -1);
        search_key(VAL_MIN);
        search_key(-1);
        search_key('0);
        search_key(VAL_MAX);
        search_key(VAL_MIN + 1);
        search_key(1);
        search_key(VAL_MAX - 1);
        search_key(32'sh5555_5555);
        search_key(32'shAAAA_AAAA);

        // full table first, then an oversized setting, then random phases
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase_no == 0)
                run_phase(stbs_pkg::DEPTH_DEFAULT);
            else if (phase_no == 1)
                run_phase((1 << stbs_pkg::TSIZE_W) - 1);
            else
                run_phase(pick_size());
            phase_no++;
        end

        settle();
        repeat (SEARCH_LATENCY + 4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sorted_table_binary_search test passed");
        else
            $display("sorted_table_binary_search test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/sorted_table_binary_search.sv
tb/sv/tb_top.sv
